// ----- design/cpa_pkg.sv -----
// Package with the shared constants, types and helper functions of the closest point of approach block.
package cpa_pkg;

   localparam int TrigSteps = 16;
   localparam int DivSteps  = 29;
   localparam int RootBits  = 36;

   localparam logic signed [35:0] TrigGain = 36'sd652032874;
   localparam logic [32:0] DistMax = 33'h1_FFFF_FFFF;

   localparam logic [2:0] RegContactNorth  = 3'd0;
   localparam logic [2:0] RegContactEast   = 3'd1;
   localparam logic [2:0] RegContactCourse = 3'd2;
   localparam logic [2:0] RegContactSpeed  = 3'd3;
   localparam logic [2:0] RegOwnNorth      = 3'd4;
   localparam logic [2:0] RegOwnEast       = 3'd5;

   typedef logic signed [35:0] trig_type;

   typedef struct packed {
      logic signed [35:0] x;
      logic signed [35:0] y;
      logic signed [35:0] z;
      logic [1:0]         quad;
   } cordic_type;

   function automatic logic signed [35:0] atan_entry(input logic [3:0] idx);
      logic signed [35:0] r;
      begin
         case (idx)
            4'd0:  r = 36'sd294912000;
            4'd1:  r = 36'sd174096719;
            4'd2:  r = 36'sd91987925;
            4'd3:  r = 36'sd46694507;
            4'd4:  r = 36'sd23437865;
            4'd5:  r = 36'sd11730358;
            4'd6:  r = 36'sd5866610;
            4'd7:  r = 36'sd2933484;
            4'd8:  r = 36'sd1466764;
            4'd9:  r = 36'sd733385;
            4'd10: r = 36'sd366693;
            4'd11: r = 36'sd183347;
            4'd12: r = 36'sd91673;
            4'd13: r = 36'sd45837;
            4'd14: r = 36'sd22918;
            default: r = 36'sd11459;
         endcase
         return r;
      end
   endfunction

   // One rotation step of the CORDIC.
   function automatic cordic_type cordic_step(input cordic_type a, input logic [3:0] idx);
      cordic_type r;
      logic signed [35:0] dx;
      logic signed [35:0] dy;
      begin
         dx = a.y >>> idx;
         dy = a.x >>> idx;
         r = a;
         if (!a.z[35]) begin
            r.x = a.x - dx;
            r.y = a.y + dy;
            r.z = a.z - atan_entry(idx);
         end else begin
            r.x = a.x + dx;
            r.y = a.y - dy;
            r.z = a.z + atan_entry(idx);
         end
         return r;
      end
   endfunction

   // Reduces a course modulo 36000 and splits it into quadrant and angle.
   function automatic cordic_type cordic_start(input logic [15:0] crs);
      cordic_type r;
      logic [15:0] c;
      logic [15:0] a;
      logic [1:0]  q;
      begin
         c = (crs >= 16'd36000) ? crs - 16'd36000 : crs;
         if (c >= 16'd27000) begin
            q = 2'd3;
            a = c - 16'd27000;
         end else if (c >= 16'd18000) begin
            q = 2'd2;
            a = c - 16'd18000;
         end else if (c >= 16'd9000) begin
            q = 2'd1;
            a = c - 16'd9000;
         end else begin
            q = 2'd0;
            a = c;
         end
         r.x = TrigGain;
         r.y = '0;
         r.z = $signed({4'd0, a, 16'd0});
         r.quad = q;
         return r;
      end
   endfunction

endpackage

// ----- design/closest_point_of_approach.sv -----
// Closest point of approach pipeline: one candidate course, speed and leg time per clock cycle
// while no result stall holds it. The block accepts one word per clock cycle when not stalled
// and returns one result word per input word. Each word passes 92 register stages. The stages
// are the course CORDIC (16 stages), the restoring time divider (29 stages) and the
// bit-per-stage range square root (36 stages), plus 11 stages for the input, velocities,
// products, sums, travel and squares. A stall on the result side holds the whole pipeline;
// results never get lost or repeated. Configuration is to be written through the csr_ port
// only while idle; the block itself does not enforce this.
module closest_point_of_approach (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // own_course[15:0], own_speed[31:16], leg_time[47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // cpa_distance[32:0], closure_rate[64:33], zeros above
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int NStage = 11 + cpa_pkg::TrigSteps + cpa_pkg::DivSteps + cpa_pkg::RootBits;

   logic signed [31:0] cn_ff, ce_ff, on_ff, oe_ff;
   logic [15:0] ccrs_ff, cspd_ff;
   logic adv;
   logic [NStage-1:0] vld_ff;
   logic [2:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cn_ff <= '0; ce_ff <= '0; on_ff <= '0; oe_ff <= '0;
         ccrs_ff <= '0; cspd_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'd0) begin
         unique case (csr_idx)
            cpa_pkg::RegContactNorth:  cn_ff <= csr_pwdata;
            cpa_pkg::RegContactEast:   ce_ff <= csr_pwdata;
            cpa_pkg::RegContactCourse: ccrs_ff <= csr_pwdata[15:0];
            cpa_pkg::RegContactSpeed:  cspd_ff <= csr_pwdata[15:0];
            cpa_pkg::RegOwnNorth:      on_ff <= csr_pwdata;
            cpa_pkg::RegOwnEast:       oe_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'd0) begin
         unique case (csr_idx)
            cpa_pkg::RegContactNorth:  csr_prdata = cn_ff;
            cpa_pkg::RegContactEast:   csr_prdata = ce_ff;
            cpa_pkg::RegContactCourse: csr_prdata = {16'd0, ccrs_ff};
            cpa_pkg::RegContactSpeed:  csr_prdata = {16'd0, cspd_ff};
            cpa_pkg::RegOwnNorth:      csr_prdata = on_ff;
            cpa_pkg::RegOwnEast:       csr_prdata = oe_ff;
            default: csr_prdata = '0;
         endcase
      end
   end

   // The pipeline moves when the last stage is empty or being taken.
   assign adv = !vld_ff[NStage-1] || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NStage-2:0], req_tvalid};
      end
   end

   // Stage group A: CORDIC for both courses.
   localparam int TS = cpa_pkg::TrigSteps;
   cpa_pkg::cordic_type ocor_ff [TS+1];
   cpa_pkg::cordic_type ccor_ff [TS+1];
   logic [15:0] ospd_a_ff [TS+1];
   logic [15:0] leg_a_ff [TS+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         ocor_ff[0] <= cpa_pkg::cordic_start(req_tdata[15:0]);
         ccor_ff[0] <= cpa_pkg::cordic_start(ccrs_ff);
         ospd_a_ff[0] <= req_tdata[31:16];
         leg_a_ff[0] <= req_tdata[47:32];
      end
   end

   for (genvar g = 0; g < TS; g++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (adv) begin
            ocor_ff[g+1] <= cpa_pkg::cordic_step(ocor_ff[g], 4'(g));
            ccor_ff[g+1] <= cpa_pkg::cordic_step(ccor_ff[g], 4'(g));
            ospd_a_ff[g+1] <= ospd_a_ff[g];
            leg_a_ff[g+1] <= leg_a_ff[g];
         end
      end
   end

   // Quadrant fix.
   function automatic void quad_fix(input cpa_pkg::cordic_type a,
                                    output logic signed [35:0] c,
                                    output logic signed [35:0] s);
      begin
         case (a.quad)
            2'd0: begin c = a.x; s = a.y; end
            2'd1: begin c = -a.y; s = a.x; end
            2'd2: begin c = -a.x; s = -a.y; end
            default: begin c = a.y; s = -a.x; end
         endcase
      end
   endfunction

   logic signed [35:0] oc, os, cc, cs;
   always_comb begin
      quad_fix(ocor_ff[TS], oc, os);
      quad_fix(ccor_ff[TS], cc, cs);
   end

   // Velocity stage: speed times trig; the shift by 22 follows in the w stage.
   logic signed [52:0] ovn_ff, ove_ff, cvn_ff, cve_ff;
   logic [15:0] leg_v_ff;
   logic signed [32:0] pn_v_ff, pe_v_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         ovn_ff <= $signed({1'b0, ospd_a_ff[TS]}) * oc;
         ove_ff <= $signed({1'b0, ospd_a_ff[TS]}) * os;
         cvn_ff <= $signed({1'b0, cspd_ff}) * cc;
         cve_ff <= $signed({1'b0, cspd_ff}) * cs;
         leg_v_ff <= leg_a_ff[TS];
         pn_v_ff <= 33'(on_ff) - 33'(cn_ff);
         pe_v_ff <= 33'(oe_ff) - 33'(ce_ff);
      end
   end

   // w stage.
   logic signed [31:0] wn_ff, we_ff;
   logic [15:0] leg_w_ff;
   logic signed [32:0] pn_w_ff, pe_w_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         wn_ff <= 32'(ovn_ff >>> 22) - 32'(cvn_ff >>> 22);
         we_ff <= 32'(ove_ff >>> 22) - 32'(cve_ff >>> 22);
         leg_w_ff <= leg_v_ff;
         pn_w_ff <= pn_v_ff;
         pe_w_ff <= pe_v_ff;
      end
   end

   // Product stage.
   logic signed [64:0] dn_ff, de_ff;
   logic [63:0] sqn_ff, sqe_ff;
   logic signed [31:0] wn_p_ff, we_p_ff;
   logic [15:0] leg_p_ff;
   logic signed [32:0] pn_p_ff, pe_p_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         dn_ff <= pn_w_ff * wn_ff;
         de_ff <= pe_w_ff * we_ff;
         sqn_ff <= $unsigned(64'(wn_ff * wn_ff));
         sqe_ff <= $unsigned(64'(we_ff * we_ff));
         wn_p_ff <= wn_ff; we_p_ff <= we_ff;
         leg_p_ff <= leg_w_ff;
         pn_p_ff <= pn_w_ff; pe_p_ff <= pe_w_ff;
      end
   end

   // Sum stage: dot, den, rate.
   logic signed [65:0] dot;
   logic [64:0] den;
   logic signed [66:0] rate_full;
   logic signed [31:0] rate_sat;
   assign dot = 66'(dn_ff) + 66'(de_ff);
   assign den = 65'(sqn_ff) + 65'(sqe_ff);
   assign rate_full = (-(67'(dot) <<< 1)) >>> 24;
   always_comb begin
      if (rate_full > 67'sd2147483647) rate_sat = 32'h7FFF_FFFF;
      else if (rate_full < -67'sd2147483648) rate_sat = 32'h8000_0000;
      else rate_sat = 32'(rate_full);
   end

   logic [65:0] num_s_ff;
   logic [64:0] den_s_ff;
   logic go_s_ff;
   logic signed [31:0] rate_s_ff, wn_s_ff, we_s_ff;
   logic [28:0] cap_s_ff;
   logic signed [32:0] pn_s_ff, pe_s_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         num_s_ff <= dot[65] ? $unsigned(-dot) : '0;
         den_s_ff <= den;
         go_s_ff <= dot[65] && den != '0;
         rate_s_ff <= rate_sat;
         wn_s_ff <= wn_p_ff; we_s_ff <= we_p_ff;
         cap_s_ff <= {1'b0, leg_p_ff, 12'd0};
         pn_s_ff <= pn_p_ff; pe_s_ff <= pe_p_ff;
      end
   end

   // Restoring divider, one quotient bit per stage, quotient saturated at 2^28.
   localparam int DS = cpa_pkg::DivSteps;
   logic [94:0] rem_ff [DS+1];
   logic [28:0] q_ff [DS+1];
   logic [64:0] dd_ff [DS+1];
   logic go_d_ff [DS+1];
   logic big_d_ff [DS+1];
   logic signed [31:0] rate_d_ff [DS+1], wn_d_ff [DS+1], we_d_ff [DS+1];
   logic [28:0] cap_d_ff [DS+1];
   logic signed [32:0] pn_d_ff [DS+1], pe_d_ff [DS+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= {5'd0, num_s_ff, 24'd0};
         q_ff[0] <= '0;
         dd_ff[0] <= den_s_ff;
         go_d_ff[0] <= go_s_ff;
         big_d_ff[0] <= {29'd0, num_s_ff} >= ({30'd0, den_s_ff} << 4);
         rate_d_ff[0] <= rate_s_ff; wn_d_ff[0] <= wn_s_ff; we_d_ff[0] <= we_s_ff;
         cap_d_ff[0] <= cap_s_ff;
         pn_d_ff[0] <= pn_s_ff; pe_d_ff[0] <= pe_s_ff;
      end
   end

   for (genvar g = 0; g < DS; g++) begin : g_div
      localparam int Sh = DS - 1 - g;
      logic [94:0] trial;
      logic fits;
      assign trial = {30'd0, dd_ff[g]} << Sh;
      assign fits = (rem_ff[g] >> Sh) >= {30'd0, dd_ff[g]};
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[g+1] <= fits ? rem_ff[g] - trial : rem_ff[g];
            q_ff[g+1] <= q_ff[g] | (fits ? (29'd1 << Sh) : 29'd0);
            dd_ff[g+1] <= dd_ff[g];
            go_d_ff[g+1] <= go_d_ff[g];
            big_d_ff[g+1] <= big_d_ff[g];
            rate_d_ff[g+1] <= rate_d_ff[g];
            wn_d_ff[g+1] <= wn_d_ff[g]; we_d_ff[g+1] <= we_d_ff[g];
            cap_d_ff[g+1] <= cap_d_ff[g];
            pn_d_ff[g+1] <= pn_d_ff[g]; pe_d_ff[g+1] <= pe_d_ff[g];
         end
      end
   end

   logic [28:0] tq, tcl;
   assign tq = big_d_ff[DS] ? 29'h1000_0000 : q_ff[DS];
   assign tcl = !go_d_ff[DS] ? '0 : (tq > cap_d_ff[DS] ? cap_d_ff[DS] : tq);

   // Travel stage.
   logic signed [61:0] mn_ff, me_ff;
   logic signed [32:0] pn_t_ff, pe_t_ff;
   logic signed [31:0] rate_t_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         mn_ff <= wn_d_ff[DS] * $signed({1'b0, tcl});
         me_ff <= we_d_ff[DS] * $signed({1'b0, tcl});
         pn_t_ff <= pn_d_ff[DS]; pe_t_ff <= pe_d_ff[DS];
         rate_t_ff <= rate_d_ff[DS];
      end
   end

   logic [38:0] an_ff, ae_ff;
   logic signed [31:0] rate_q_ff;
   logic signed [38:0] fn, fe;
   assign fn = 39'(pn_t_ff) + 39'(mn_ff >>> 24);
   assign fe = 39'(pe_t_ff) + 39'(me_ff >>> 24);
   always_ff @(posedge clock) begin
      if (adv) begin
         an_ff <= fn[38] ? $unsigned(-fn) : $unsigned(fn);
         ae_ff <= fe[38] ? $unsigned(-fe) : $unsigned(fe);
         rate_q_ff <= rate_t_ff;
      end
   end

   // Square stages: each square is built from partial products of its upper and lower halves.
   logic [37:0] hhn_ff, hhe_ff;
   logic [38:0] hln_ff, hle_ff;
   logic [39:0] lln_ff, lle_ff;
   logic signed [31:0] rate_h_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         hhn_ff <= an_ff[38:20] * an_ff[38:20];
         hln_ff <= an_ff[38:20] * an_ff[19:0];
         lln_ff <= an_ff[19:0] * an_ff[19:0];
         hhe_ff <= ae_ff[38:20] * ae_ff[38:20];
         hle_ff <= ae_ff[38:20] * ae_ff[19:0];
         lle_ff <= ae_ff[19:0] * ae_ff[19:0];
         rate_h_ff <= rate_q_ff;
      end
   end

   logic [78:0] rad_ff;
   logic signed [31:0] rate_r_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff <= (79'(hhn_ff) << 40) + (79'(hln_ff) << 21) + 79'(lln_ff)
                 + (79'(hhe_ff) << 40) + (79'(hle_ff) << 21) + 79'(lle_ff);
         rate_r_ff <= rate_h_ff;
      end
   end

   // Bit-per-stage square root (remainder form).
   localparam int RB = cpa_pkg::RootBits;
   logic [78:0] rr_ff [RB+1];
   logic [35:0] root_ff [RB+1];
   logic signed [31:0] rate_x_ff [RB+1];
   always_ff @(posedge clock) begin
      if (adv) begin
         rr_ff[0] <= rad_ff;
         root_ff[0] <= '0;
         rate_x_ff[0] <= rate_r_ff;
      end
   end

   for (genvar g = 0; g < RB; g++) begin : g_root
      localparam int B = RB - 1 - g;
      logic [78:0] need;
      assign need = ({43'd0, root_ff[g]} << (B + 1)) + (79'd1 << (2 * B));
      always_ff @(posedge clock) begin
         if (adv) begin
            if (rr_ff[g] >= need) begin
               rr_ff[g+1] <= rr_ff[g] - need;
               root_ff[g+1] <= root_ff[g] | (36'd1 << B);
            end else begin
               rr_ff[g+1] <= rr_ff[g];
               root_ff[g+1] <= root_ff[g];
            end
            rate_x_ff[g+1] <= rate_x_ff[g];
         end
      end
   end

   logic [32:0] distance;
   assign distance = root_ff[RB] > 36'(cpa_pkg::DistMax) ? cpa_pkg::DistMax : root_ff[RB][32:0];

   assign rsp_tvalid = vld_ff[NStage-1];
   assign rsp_tdata = {7'd0, rate_x_ff[RB], distance};

endmodule

// ----- design/cpa_checker.sv -----
// Port checker for the closest point of approach block, bound to its top level.
module cpa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic        csr_pready
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled result word changed.");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("Input taken during result stall.");

   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[71:65] == 7'd0)
      else $error("Result padding not zero.");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("Register port not ready.");

endmodule

bind closest_point_of_approach cpa_checker u_cpa_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .csr_pready(csr_pready)
);
